[rtl/bd_pkg.sv]
// Shared types and constants for the power-of-two box downsampler.
// No dependencies; every other file of the block refers to it by scoped names.
package bd_pkg;

    // Channel and accumulator geometry
    localparam int CHANS  = 4;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 28;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Register reset values
    localparam logic [3:0] RST_LOG2_SRC_W   = 4'd8;
    localparam logic [3:0] RST_LOG2_SRC_H   = 4'd8;
    localparam logic [2:0] RST_LOG2_MAX_DIM = 3'd6;

    // Parameter defaults
    localparam int DEF_MAX_SRC_LOG2 = 10;
    localparam int DEF_MAX_OUT_LOG2 = 6;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_SRC_W   = 2'd0,
        REG_LOG2_SRC_H   = 2'd1,
        REG_LOG2_MAX_DIM = 2'd2
    } cfg_reg_t;

    typedef logic [CHANS-1:0][CH_W-1:0]  pix_t;
    typedef logic [CHANS-1:0][SUM_W-1:0] sums_t;

    // Geometry derived from the registers
    typedef struct packed {
        logic [3:0] sw;     // saturated log2 source width
        logic [3:0] sh;     // saturated log2 source height
        logic [3:0] kx;     // log2 box width
        logic [3:0] ky;     // log2 box height
        logic [4:0] shamt;  // kx + ky
    } geom_t;

    // Per-pixel box position flags
    typedef struct packed {
        logic first;  // first pixel of its box
        logic done;   // bottom-right pixel of its box
        logic last;   // last pixel of the image
    } tag_t;

    // One result beat
    typedef struct packed {
        pix_t mean;
        logic last;
    } res_t;

endpackage

[rtl/bd_ifs.sv]
// Stream and configuration interfaces of the box downsampler.
// Depends on bd_pkg for field widths.
interface bd_pix_if;
    logic                   valid;
    logic                   ready;
    logic [bd_pkg::CH_W-1:0] chan0;
    logic [bd_pkg::CH_W-1:0] chan1;
    logic [bd_pkg::CH_W-1:0] chan2;
    logic [bd_pkg::CH_W-1:0] chan3;
    modport source (output valid, chan0, chan1, chan2, chan3, input ready);
    modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface bd_mean_if;
    logic                   valid;
    logic                   ready;
    logic [bd_pkg::CH_W-1:0] mean0;
    logic [bd_pkg::CH_W-1:0] mean1;
    logic [bd_pkg::CH_W-1:0] mean2;
    logic [bd_pkg::CH_W-1:0] mean3;
    logic                   last_pixel;
    modport source (output valid, mean0, mean1, mean2, mean3, last_pixel, input ready);
    modport sink   (input valid, mean0, mean1, mean2, mean3, last_pixel, output ready);
endinterface

interface bd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bd_pkg::CFG_IDX_W-1:0]  index;
    logic [bd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bd_cfg.sv]
// Configuration registers and derived box geometry.
// Depends on bd_pkg.
module bd_cfg #(
    parameter int MAX_SRC_LOG2 = bd_pkg::DEF_MAX_SRC_LOG2,
    parameter int MAX_OUT_LOG2 = bd_pkg::DEF_MAX_OUT_LOG2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [bd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bd_pkg::CFG_DATA_W-1:0] wr_data,
    output bd_pkg::geom_t                 geom
);

    logic [3:0] log2_src_w_reg;
    logic [3:0] log2_src_h_reg;
    logic [2:0] log2_max_dim_reg;
    logic [3:0] sw, sh, cap, lw, lh;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_src_w_reg   <= bd_pkg::RST_LOG2_SRC_W;
            log2_src_h_reg   <= bd_pkg::RST_LOG2_SRC_H;
            log2_max_dim_reg <= bd_pkg::RST_LOG2_MAX_DIM;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bd_pkg::REG_LOG2_SRC_W:   log2_src_w_reg   <= wr_data[3:0];
                bd_pkg::REG_LOG2_SRC_H:   log2_src_h_reg   <= wr_data[3:0];
                bd_pkg::REG_LOG2_MAX_DIM: log2_max_dim_reg <= wr_data[2:0];
                default:                  ;  // unmapped index: restart only
            endcase
        end
    end

    // Saturate, then split each axis into output size and box size
    always_comb
    begin
        sw  = (log2_src_w_reg > 4'(MAX_SRC_LOG2)) ? 4'(MAX_SRC_LOG2) : log2_src_w_reg;
        sh  = (log2_src_h_reg > 4'(MAX_SRC_LOG2)) ? 4'(MAX_SRC_LOG2) : log2_src_h_reg;
        cap = ({1'b0, log2_max_dim_reg} > 4'(MAX_OUT_LOG2)) ? 4'(MAX_OUT_LOG2)
                                                            : {1'b0, log2_max_dim_reg};
        lw  = (sw < cap) ? sw : cap;
        lh  = (sh < cap) ? sh : cap;
        geom.sw    = sw;
        geom.sh    = sh;
        geom.kx    = sw - lw;
        geom.ky    = sh - lh;
        geom.shamt = 5'(sw - lw) + 5'(sh - lh);
    end

endmodule

[rtl/bd_addr.sv]
// Source position counters and per-pixel column address and box flags.
// Depends on bd_pkg.
module bd_addr #(
    parameter int MAX_SRC_LOG2 = bd_pkg::DEF_MAX_SRC_LOG2,
    parameter int MAX_OUT_LOG2 = bd_pkg::DEF_MAX_OUT_LOG2,
    localparam int OX_W = (MAX_OUT_LOG2 > 0) ? MAX_OUT_LOG2 : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic            advance,
    input  bd_pkg::geom_t   geom,
    output logic [OX_W-1:0] ox,
    output bd_pkg::tag_t    tag
);

    localparam int SRC_W = MAX_SRC_LOG2;
    localparam int EXT_W = (SRC_W > OX_W) ? SRC_W : OX_W;

    logic [SRC_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [SRC_W-1:0] col, row, wmask, hmask, bxmask, bymask, col_sh;
    logic [EXT_W-1:0] col_ext;
    logic [SRC_W:0]   one_w;

    // Axis and box masks
    always_comb
    begin
        one_w   = (SRC_W + 1)'(1);
        wmask   = SRC_W'((one_w << geom.sw) - one_w);
        hmask   = SRC_W'((one_w << geom.sh) - one_w);
        bxmask  = SRC_W'((one_w << geom.kx) - one_w);
        bymask  = SRC_W'((one_w << geom.ky) - one_w);
        col     = col_reg & wmask;
        row     = row_reg & hmask;
        col_sh  = col >> geom.kx;
        col_ext = EXT_W'(col_sh);
    end

    // Column address and flags of the pixel at the head of the stream
    assign ox = (MAX_OUT_LOG2 == 0) ? '0 : col_ext[OX_W-1:0];
    assign tag.first = ((col & bxmask) == '0) && ((row & bymask) == '0);
    assign tag.done  = ((col & bxmask) == bxmask) && ((row & bymask) == bymask);
    assign tag.last  = (col == wmask) && (row == hmask);

    // Raster advance with wrap at end of line and end of image
    always_comb
    begin
        if (col == wmask)
        begin
            col_next = '0;
            row_next = (row == hmask) ? '0 : row + SRC_W'(1);
        end
        else
        begin
            col_next = col + SRC_W'(1);
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // After the image's final pixel the position is back at the origin
    a_wrap_origin: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tag.last |=> col_reg == '0 && row_reg == '0)
        else $error("position did not wrap after last pixel");

endmodule

[rtl/bd_accum.sv]
// Column sum memory with read-modify-write pipeline, forwarding and mean shift.
// Depends on bd_pkg.
module bd_accum #(
    parameter int MAX_OUT_LOG2 = bd_pkg::DEF_MAX_OUT_LOG2,
    localparam int OX_W  = (MAX_OUT_LOG2 > 0) ? MAX_OUT_LOG2 : 1,
    localparam int DEPTH = 1 << MAX_OUT_LOG2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [OX_W-1:0] rd_addr,
    input  bd_pkg::tag_t    rd_tag,
    input  bd_pkg::pix_t    rd_pix,
    input  logic [4:0]      shamt,
    output logic            push,
    output bd_pkg::res_t    push_data
);

    bd_pkg::sums_t   sum_mem [DEPTH];
    bd_pkg::sums_t   rd_data_reg;
    bd_pkg::sums_t   wb_data_reg;
    bd_pkg::sums_t   base, sum_next;
    logic            s1_valid_reg;
    bd_pkg::tag_t    s1_tag_reg;
    logic [OX_W-1:0] s1_ox_reg;
    bd_pkg::pix_t    s1_pix_reg;
    logic            wb_valid_reg;
    logic [OX_W-1:0] wb_addr_reg;
    logic            fwd;

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= sum_mem[rd_addr];
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            sum_mem[s1_ox_reg] <= sum_next;
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            wb_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 payload and the last write for forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_tag_reg <= rd_tag;
            s1_ox_reg  <= rd_addr;
            s1_pix_reg <= rd_pix;
        end
        if (s1_valid_reg)
        begin
            wb_addr_reg <= s1_ox_reg;
            wb_data_reg <= sum_next;
        end
    end

    // The write on the edge that read this entry is not in the read data
    assign fwd = wb_valid_reg && (wb_addr_reg == s1_ox_reg);

    // Accumulate and scale each channel
    always_comb
    begin
        if (s1_tag_reg.first)
            base = '0;
        else if (fwd)
            base = wb_data_reg;
        else
            base = rd_data_reg;
        for (int c = 0; c < bd_pkg::CHANS; c++)
        begin
            sum_next[c]       = base[c] + bd_pkg::SUM_W'(s1_pix_reg[c]);
            push_data.mean[c] = bd_pkg::CH_W'(sum_next[c] >> shamt);
        end
        push_data.last = s1_tag_reg.last;
    end

    assign push = s1_valid_reg && s1_tag_reg.done;

    // Forwarding only follows a write on the previous edge
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        fwd |-> $past(s1_valid_reg))
        else $error("forwarding without a preceding write");

endmodule

[rtl/bd_ofifo.sv]
// Four-beat output queue that decouples the result port from the pipeline.
// Depends on bd_pkg.
module bd_ofifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bd_pkg::res_t push_data,
    input  logic         pending,
    output logic         space_ok,
    output logic         out_valid,
    input  logic         out_ready,
    output bd_pkg::res_t out_data
);

    bd_pkg::res_t                q_mem [bd_pkg::OQ_DEPTH];
    logic [bd_pkg::OQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bd_pkg::OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                        pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Room for one more pixel counting the beat about to be pushed
    assign space_ok = (cnt_reg + bd_pkg::OQ_CNT_W'(pending))
                      < bd_pkg::OQ_CNT_W'(bd_pkg::OQ_DEPTH);

    always_comb
    begin
        cnt_next = cnt_reg + bd_pkg::OQ_CNT_W'(push) - bd_pkg::OQ_CNT_W'(pop);
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bd_pkg::OQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bd_pkg::OQ_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bd_pkg::OQ_CNT_W'(bd_pkg::OQ_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg < bd_pkg::OQ_CNT_W'(bd_pkg::OQ_DEPTH))
        else $error("push into full output queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - bd_pkg::OQ_CNT_W'(1))
        else $error("output queue count lost a pop");

endmodule

[rtl/box_downsample_rgba.sv]
// Power-of-two box-filter downsampler for four-channel 8-bit pixels.
// Source pixels enter on the pixel channel in raster order, one beat each,
// for an image of 2^log2_src_width by 2^log2_src_height, each log2 saturated
// at MAX_SRC_LOG2. Each output axis is min(source size, 2^log2_max_dim), with
// log2_max_dim saturated at MAX_OUT_LOG2; each result beat on the result
// channel is the per-channel truncated mean of one box, with last_pixel set on
// the final box of the image. Registers are written on the cfg channel (index
// 0 width, 1 height, 2 output cap); any write, at any index, restarts the
// image at its first pixel. cfg is always ready; the user must write it only
// while idle, and the block does not enforce this. Throughput: one pixel per
// cycle sustained while the output queue has room. A column sum is read from
// the sum memory on the accept edge and written back on the next edge, with
// the last write forwarded when consecutive pixels share a column. Stall: a
// four-beat output queue absorbs results; pixel.ready drops when the queue
// plus the result in flight would fill it, and the stream resumes at full rate
// once result.ready returns. Reset: registers return to 8, 8, 6 and the
// position to the first pixel; the sum memory needs no clearing since each
// box's first pixel overwrites it.
module box_downsample_rgba #(
    parameter int MAX_SRC_LOG2 = bd_pkg::DEF_MAX_SRC_LOG2,
    parameter int MAX_OUT_LOG2 = bd_pkg::DEF_MAX_OUT_LOG2
) (
    input  logic             clk,
    input  logic             rst_n,
    bd_pix_if.sink           pixel,
    bd_mean_if.source        result,
    bd_cfg_if.sink           cfg
);

    localparam int OX_W = (MAX_OUT_LOG2 > 0) ? MAX_OUT_LOG2 : 1;

    bd_pkg::geom_t   geom;
    bd_pkg::tag_t    tag;
    bd_pkg::pix_t    pix;
    bd_pkg::res_t    push_data, out_data;
    logic [OX_W-1:0] ox;
    logic            cfg_fire, pix_fire, push, space_ok;

    // Handshakes
    assign cfg.ready    = 1'b1;
    assign cfg_fire     = cfg.valid && cfg.ready;
    assign pixel.ready  = space_ok;
    assign pix_fire     = pixel.valid && pixel.ready;
    assign pix          = {pixel.chan3, pixel.chan2, pixel.chan1, pixel.chan0};

    bd_cfg #(
        .MAX_SRC_LOG2 (MAX_SRC_LOG2),
        .MAX_OUT_LOG2 (MAX_OUT_LOG2)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_fire),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .geom     (geom)
    );

    bd_addr #(
        .MAX_SRC_LOG2 (MAX_SRC_LOG2),
        .MAX_OUT_LOG2 (MAX_OUT_LOG2)
    ) u_addr (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_fire),
        .advance (pix_fire),
        .geom    (geom),
        .ox      (ox),
        .tag     (tag)
    );

    bd_accum #(
        .MAX_OUT_LOG2 (MAX_OUT_LOG2)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (pix_fire),
        .rd_addr   (ox),
        .rd_tag    (tag),
        .rd_pix    (pix),
        .shamt     (geom.shamt),
        .push      (push),
        .push_data (push_data)
    );

    bd_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pending   (push),
        .space_ok  (space_ok),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    // Result beat
    assign result.mean0      = out_data.mean[0];
    assign result.mean1      = out_data.mean[1];
    assign result.mean2      = out_data.mean[2];
    assign result.mean3      = out_data.mean[3];
    assign result.last_pixel = out_data.last;

endmodule

[tb/tb.sv]
// Testbench for box_downsample_rgba: directed rows, then random pixel phases
// over many image geometries, checked against an in-bench box-mean predictor.
// Depends on rtl/bd_pkg.sv, rtl/bd_ifs.sv and rtl/box_downsample_rgba.sv.
`timescale 1ns / 1ps

module tb;

    localparam int SRC_LOG2_CAP = bd_pkg::DEF_MAX_SRC_LOG2;
    localparam int OUT_LOG2_CAP = bd_pkg::DEF_MAX_OUT_LOG2;
    localparam int SUM_COLS     = 1 << OUT_LOG2_CAP;
    localparam int SETTLE_CYC   = 6;
    localparam int HANG_LIMIT   = 2000;
    localparam int RAND_ITEMS   = 900;
    localparam logic [bd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum bit {ROW_REG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [bd_pkg::CFG_IDX_W-1:0]   idx;
        logic [bd_pkg::CFG_DATA_W-1:0]  val;
        bd_pkg::pix_t                   px;
        bit                             typed;
        bd_pkg::res_t                   want;
    } row_t;

    typedef struct {
        bit           typed;
        bd_pkg::res_t want;
    } pix_note_t;

    typedef struct {
        logic [3:0] w;
        logic [3:0] h;
        logic [3:0] cap;
        int         n;
    } phase_t;

    logic clk;
    logic rst_n;

    bd_pix_if  pix_bus();
    bd_mean_if mean_bus();
    bd_cfg_if  cfg_bus();

    box_downsample_rgba u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_bus),
        .result (mean_bus),
        .cfg    (cfg_bus)
    );

    // Predictor state: registers, column sums, raster position
    logic [3:0]               w_reg   = bd_pkg::RST_LOG2_SRC_W;
    logic [3:0]               h_reg   = bd_pkg::RST_LOG2_SRC_H;
    logic [2:0]               cap_reg = bd_pkg::RST_LOG2_MAX_DIM;
    logic [bd_pkg::SUM_W-1:0] box_sum [bd_pkg::CHANS][SUM_COLS];
    logic [9:0]               pos_col = '0;
    logic [9:0]               pos_row = '0;

    bd_pkg::res_t pending_means [$];
    pix_note_t    pix_notes [$];
    int           err_count  = 0;
    int           idle_cyc   = 0;
    int           rand_sent  = 0;
    int           tx_count   = 0;
    bit           tx_calm    = 0;
    bit           rx_calm    = 0;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bd_pkg::pix_t mk_px(logic [7:0] c0, logic [7:0] c1,
                                           logic [7:0] c2, logic [7:0] c3);
        bd_pkg::pix_t p;
        p[0] = c0;
        p[1] = c1;
        p[2] = c2;
        p[3] = c3;
        return p;
    endfunction

    function automatic bd_pkg::res_t mk_res(bd_pkg::pix_t p, logic last);
        bd_pkg::res_t r;
        r.mean = p;
        r.last = last;
        return r;
    endfunction

    function automatic row_t reg_row(logic [bd_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bd_pkg::CFG_DATA_W-1:0] val);
        row_t r;
        r = '{kind: ROW_REG, default: '0};
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic row_t pix_row(bd_pkg::pix_t px);
        row_t r;
        r = '{kind: ROW_PIX, default: '0};
        r.px   = px;
        return r;
    endfunction

    function automatic row_t pix_chk(bd_pkg::pix_t px, bd_pkg::res_t want);
        row_t r;
        r = pix_row(px);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Register write as the block sees it; any index restarts the image
    function automatic void load_reg(logic [bd_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bd_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            bd_pkg::REG_LOG2_SRC_W:   w_reg   = d;
            bd_pkg::REG_LOG2_SRC_H:   h_reg   = d;
            bd_pkg::REG_LOG2_MAX_DIM: cap_reg = d[2:0];
            default: ;
        endcase
        pos_col = '0;
        pos_row = '0;
    endfunction

    // One source pixel into the column sums; returns 1 when a box completes
    function automatic bit predict_box(input bd_pkg::pix_t px, output bd_pkg::res_t r);
        int sw, sh, cap, lw, lh, kx, ky;
        int wmask, hmask, bxm, bym, col, row, ox, c;
        bit first, done;
        sw    = (w_reg > SRC_LOG2_CAP) ? SRC_LOG2_CAP : int'(w_reg);
        sh    = (h_reg > SRC_LOG2_CAP) ? SRC_LOG2_CAP : int'(h_reg);
        cap   = (cap_reg > OUT_LOG2_CAP) ? OUT_LOG2_CAP : int'(cap_reg);
        lw    = (sw < cap) ? sw : cap;
        lh    = (sh < cap) ? sh : cap;
        kx    = sw - lw;
        ky    = sh - lh;
        wmask = (1 << sw) - 1;
        hmask = (1 << sh) - 1;
        bxm   = (1 << kx) - 1;
        bym   = (1 << ky) - 1;
        col   = int'(pos_col) & wmask;
        row   = int'(pos_row) & hmask;
        ox    = (col >> kx) & (SUM_COLS - 1);
        first = ((col & bxm) == 0) && ((row & bym) == 0);
        done  = ((col & bxm) == bxm) && ((row & bym) == bym);
        r = '0;
        for (c = 0; c < bd_pkg::CHANS; c++)
        begin
            if (first)
                box_sum[c][ox] = bd_pkg::SUM_W'(px[c]);
            else
                box_sum[c][ox] = box_sum[c][ox] + bd_pkg::SUM_W'(px[c]);
            r.mean[c] = 8'(box_sum[c][ox] >> (kx + ky));
        end
        r.last = (col == wmask) && (row == hmask);
        // raster advance, wrapping at the end of the image
        if (col == wmask)
        begin
            col = 0;
            row = (row == hmask) ? 0 : row + 1;
        end
        else
            col++;
        pos_col = 10'(col);
        pos_row = 10'(row);
        return done;
    endfunction

    // Bias toward the channel extremes
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Pixel source: optional gap, then hold the beat until accepted
    task automatic send_pix(bd_pkg::pix_t px, bit typed, bd_pkg::res_t want);
        int gap;
        pix_note_t note;
        if (tx_count % 32 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        tx_count++;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note.typed = typed;
        note.want  = want;
        pix_notes.push_back(note);
        pix_bus.valid <= 1'b1;
        pix_bus.chan0 <= px[0];
        pix_bus.chan1 <= px[1];
        pix_bus.chan2 <= px[2];
        pix_bus.chan3 <= px[3];
        @(posedge clk);
        while (!pix_bus.ready) @(posedge clk);
    endtask

    // Wait for every expected mean, then let the pipeline settle
    task automatic wait_drain();
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [bd_pkg::CFG_IDX_W-1:0] idx,
                             logic [bd_pkg::CFG_DATA_W-1:0] d);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reconfigure while idle, then stream random pixels
    task automatic run_phase(phase_t ph, bit spare);
        int i;
        wait_drain();
        write_reg(bd_pkg::REG_LOG2_SRC_W, ph.w);
        write_reg(bd_pkg::REG_LOG2_SRC_H, ph.h);
        write_reg(bd_pkg::REG_LOG2_MAX_DIM, ph.cap);
        if (spare)
            write_reg(REG_SPARE, 4'($urandom_range(0, 15)));
        for (i = 0; i < ph.n; i++)
            send_pix(mk_px(rand_chan(), rand_chan(), rand_chan(), rand_chan()), 1'b0, '0);
        rand_sent += ph.n;
    endtask

    // Result sink: random stall before each beat, calm stretches now and then
    initial
    begin : result_sink
        int stall;
        int beats;
        beats = 0;
        mean_bus.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (beats % 24 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            beats++;
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                mean_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mean_bus.ready <= 1'b1;
            @(posedge clk);
            while (!mean_bus.valid) @(posedge clk);
        end
    end

    // Monitor: predict on pixel beats, check result beats, watch for a hang
    always @(posedge clk)
    begin : beat_monitor
        bit           hit;
        bit           moved;
        bd_pkg::res_t pred;
        bd_pkg::res_t got;
        bd_pkg::res_t want;
        pix_note_t    note;
        bd_pkg::pix_t px;
        int           c;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                load_reg(cfg_bus.index, cfg_bus.data);
                moved = 1'b1;
            end
            if (pix_bus.valid && pix_bus.ready)
            begin
                px  = mk_px(pix_bus.chan0, pix_bus.chan1, pix_bus.chan2, pix_bus.chan3);
                hit = predict_box(px, pred);
                note = pix_notes.pop_front();
                if (note.typed)
                    pending_means.push_back(note.want);
                else if (hit)
                    pending_means.push_back(pred);
                moved = 1'b1;
            end
            if (mean_bus.valid && mean_bus.ready)
            begin
                got.mean = mk_px(mean_bus.mean0, mean_bus.mean1,
                                 mean_bus.mean2, mean_bus.mean3);
                got.last = mean_bus.last_pixel;
                if (pending_means.size() == 0)
                begin
                    $error("result beat with no mean expected");
                    err_count++;
                end
                else
                begin
                    want = pending_means.pop_front();
                    for (c = 0; c < bd_pkg::CHANS; c++)
                        if (got.mean[c] !== want.mean[c])
                        begin
                            $error("mean%0d expected %0h got %0h", c, want.mean[c],
                                   got.mean[c]);
                            err_count++;
                        end
                    if (got.last !== want.last)
                    begin
                        $error("last_pixel expected %0b got %0b", want.last, got.last);
                        err_count++;
                    end
                end
                moved = 1'b1;
            end
            idle_cyc = moved ? 0 : idle_cyc + 1;
            if (idle_cyc >= HANG_LIMIT)
            begin
                $error("no beat on any channel for %0d cycles", HANG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        row_t   dir_rows [20];
        phase_t fixed_phases [7];
        phase_t ph;
        int     i;
        int     sz;

        pix_bus.valid <= 1'b0;
        pix_bus.chan0 <= '0;
        pix_bus.chan1 <= '0;
        pix_bus.chan2 <= '0;
        pix_bus.chan3 <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data  <= '0;
        for (i = 0; i < SUM_COLS; i++)
        begin
            box_sum[0][i] = '0;
            box_sum[1][i] = '0;
            box_sum[2][i] = '0;
            box_sum[3][i] = '0;
        end

        dir_rows = '{
            // height 1 row, width and cap still at reset: 4x1 boxes
            reg_row(bd_pkg::REG_LOG2_SRC_H, 4'd0),
            pix_row(mk_px(8'hff, 8'h00, 8'h01, 8'hff)),
            pix_row(mk_px(8'hff, 8'h00, 8'h00, 8'hff)),
            pix_row(mk_px(8'hff, 8'h00, 8'h00, 8'hfe)),
            pix_chk(mk_px(8'hff, 8'h00, 8'h00, 8'hfe),
                    mk_res(mk_px(8'hff, 8'h00, 8'h00, 8'hfe), 1'b0)),
            // 1x1 image: every pixel echoed and flagged last
            reg_row(bd_pkg::REG_LOG2_SRC_W, 4'd0),
            pix_chk(mk_px(8'h00, 8'h00, 8'h00, 8'h00),
                    mk_res(mk_px(8'h00, 8'h00, 8'h00, 8'h00), 1'b1)),
            pix_chk(mk_px(8'hff, 8'hff, 8'hff, 8'hff),
                    mk_res(mk_px(8'hff, 8'hff, 8'hff, 8'hff), 1'b1)),
            pix_chk(mk_px(8'h55, 8'haa, 8'h0f, 8'hf0),
                    mk_res(mk_px(8'h55, 8'haa, 8'h0f, 8'hf0), 1'b1)),
            // 2x1 image squeezed to one pixel
            reg_row(bd_pkg::REG_LOG2_SRC_W, 4'd1),
            reg_row(bd_pkg::REG_LOG2_MAX_DIM, 4'd0),
            pix_row(mk_px(8'hff, 8'hff, 8'h00, 8'h01)),
            pix_chk(mk_px(8'hff, 8'hfe, 8'h00, 8'h00),
                    mk_res(mk_px(8'hff, 8'hfe, 8'h00, 8'h00), 1'b1)),
            // half a box, then a write to the unused index restarts the image
            pix_row(mk_px(8'h10, 8'h20, 8'h30, 8'h40)),
            reg_row(REG_SPARE, 4'hf),
            pix_row(mk_px(8'h00, 8'h00, 8'h00, 8'h00)),
            pix_chk(mk_px(8'h02, 8'h04, 8'h06, 8'h08),
                    mk_res(mk_px(8'h01, 8'h02, 8'h03, 8'h04), 1'b1)),
            // oversized cap saturates, 2x1 passes through
            reg_row(bd_pkg::REG_LOG2_MAX_DIM, 4'd7),
            pix_chk(mk_px(8'h12, 8'h34, 8'h56, 8'h78),
                    mk_res(mk_px(8'h12, 8'h34, 8'h56, 8'h78), 1'b0)),
            pix_chk(mk_px(8'h9a, 8'hbc, 8'hde, 8'hf0),
                    mk_res(mk_px(8'h9a, 8'hbc, 8'hde, 8'hf0), 1'b1))
        };

        // Extreme geometries; the wide and tall ones stop mid-image
        fixed_phases = '{
            '{w: 4'd15, h: 4'd0,  cap: 4'd7, n: 160},
            '{w: 4'd0,  h: 4'd15, cap: 4'd6, n: 128},
            '{w: 4'd10, h: 4'd0,  cap: 4'd6, n: 64},
            '{w: 4'd3,  h: 4'd3,  cap: 4'd0, n: 64},
            '{w: 4'd2,  h: 4'd2,  cap: 4'd7, n: 32},
            '{w: 4'd6,  h: 4'd0,  cap: 4'd6, n: 64},
            '{w: 4'd4,  h: 4'd3,  cap: 4'd1, n: 128}
        };

        wait (rst_n);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                wait_drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                send_pix(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (fixed_phases[i])
            run_phase(fixed_phases[i], 1'b0);

        // Small random images: whole, repeated or cut short
        while (rand_sent < RAND_ITEMS)
        begin
            ph.w   = 4'($urandom_range(0, 5));
            ph.h   = 4'($urandom_range(0, 6 - int'(ph.w)));
            ph.cap = 4'($urandom_range(0, 7));
            sz     = 1 << (ph.w + ph.h);
            if ($urandom_range(0, 3) == 0)
                ph.n = $urandom_range(1, sz);
            else
                ph.n = sz * $urandom_range(1, 2);
            run_phase(ph, $urandom_range(0, 4) == 0);
        end

        wait_drain();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
